// ===== rtl/core/prpe_pkg.sv =====
// Shared types and constants for the planar to RGB555 palette expander.
package prpe_pkg;

    localparam int PIX_PER_COL  = 8;
    localparam int PIX_NUM_W    = $clog2(PIX_PER_COL);
    localparam int PAL_IDX_W    = 12;
    localparam int PAL_ENTRY_W  = 12;
    localparam int PAL_DEPTH    = 4096;
    localparam int LEVEL_W      = 4;
    localparam int CHAN_W       = 5;
    localparam int COLOR_W      = 15;
    localparam int PLANES_W     = 32;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_COLUMN = 1'b1;

    localparam logic CFG_PLANE_GROUP = 1'b0;
    localparam logic CFG_DISPLAY     = 1'b1;

    typedef struct packed {
        logic                   op;
        logic [PLANES_W-1:0]    green_planes;
        logic [PLANES_W-1:0]    red_planes;
        logic [PLANES_W-1:0]    blue_planes;
        logic [PAL_IDX_W-1:0]   palette_index;
        logic [LEVEL_W-1:0]     palette_red;
        logic [LEVEL_W-1:0]     palette_green;
        logic [LEVEL_W-1:0]     palette_blue;
    } t_in_item;

    typedef struct packed {
        logic [COLOR_W-1:0]     pixel_color;
        logic [PIX_NUM_W-1:0]   pixel_number;
        logic                   last_pixel;
    } t_out_item;

    typedef struct packed {
        logic                                   op;
        logic [PIX_PER_COL-1:0][PAL_IDX_W-1:0]  idx;
        logic [PAL_IDX_W-1:0]                   windex;
        logic [PAL_ENTRY_W-1:0]                 wdata;
    } t_work;

    function automatic logic [CHAN_W-1:0] expand_level(input logic [LEVEL_W-1:0] v);
        expand_level = {v, (v != '0)};
    endfunction

endpackage

// ===== rtl/core/planar_to_rgb555_palette_expander_core.sv =====
// Top level: configuration registers and the input, queue and lookup stages.
// A pixel-column item yields eight pixels, one per cycle while the output is not
// stalled, through the single palette read port; a palette-write item writes the
// palette and yields nothing. A column passes through the input stage register, the
// queue, the palette read register and the output register.
// Synchronous active-low reset clears control state and sets plane_group_enable to 7
// and display_enable to 1; palette contents are undefined until written.
module planar_to_rgb555_palette_expander_core #(
    parameter int QUEUE_DEPTH = prpe_pkg::QUEUE_DEPTH,
    parameter int PAL_DEPTH   = prpe_pkg::PAL_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  prpe_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output prpe_pkg::t_out_item  o_out_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import prpe_pkg::*;

    logic [2:0]  r_plane_group_enable;
    logic        r_display_enable;
    logic        cfg_wr;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    t_work       push_work;
    t_work       head_work;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == CFG_PLANE_GROUP) ? {29'd0, r_plane_group_enable}
                                                  : {31'd0, r_display_enable};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_group_enable <= 3'd7;
            r_display_enable     <= 1'b1;
        end else if (cfg_wr) begin
            if (paddr[2] == CFG_PLANE_GROUP) begin
                r_plane_group_enable <= pwdata[2:0];
            end else begin
                r_display_enable <= pwdata[0];
            end
        end
    end

    prpe_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_in_item            (i_in_item),
        .i_plane_group_enable (r_plane_group_enable),
        .o_push               (push),
        .o_work               (push_work),
        .i_queue_full         (full)
    );

    prpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_work),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (head_work)
    );

    prpe_back #(
        .PAL_DEPTH (PAL_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_work           (head_work),
        .o_pop            (pop),
        .i_display_enable (r_display_enable),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_item       (o_out_item)
    );
endmodule

// ===== rtl/core/prpe_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module prpe_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/prpe_front.sv =====
// Input stage: accepts items, builds the eight masked palette indices of a column.
module prpe_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  prpe_pkg::t_in_item   i_in_item,
    input  logic [2:0]           i_plane_group_enable,
    output logic                 o_push,
    output prpe_pkg::t_work      o_work,
    input  logic                 i_queue_full
);
    import prpe_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_work  r_work;
    t_work  n_work;
    logic   accept;
    logic [PAL_IDX_W-1:0] mask;

    assign o_in_stall = r_valid && i_queue_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_queue_full;
    assign n_valid    = accept || (r_valid && i_queue_full);

    assign mask = {{4{i_plane_group_enable[2]}}, {4{i_plane_group_enable[1]}},
                   {4{i_plane_group_enable[0]}}};

    always_comb begin
        n_work        = r_work;
        if (accept) begin
            n_work.op     = i_in_item.op;
            n_work.windex = i_in_item.palette_index;
            n_work.wdata  = {i_in_item.palette_red, i_in_item.palette_green,
                             i_in_item.palette_blue};
            for (int p = 0; p < PIX_PER_COL; p++) begin
                n_work.idx[p] = mask & {
                    i_in_item.green_planes[24 + 7 - p], i_in_item.green_planes[16 + 7 - p],
                    i_in_item.green_planes[8 + 7 - p],  i_in_item.green_planes[7 - p],
                    i_in_item.red_planes[24 + 7 - p],   i_in_item.red_planes[16 + 7 - p],
                    i_in_item.red_planes[8 + 7 - p],    i_in_item.red_planes[7 - p],
                    i_in_item.blue_planes[24 + 7 - p],  i_in_item.blue_planes[16 + 7 - p],
                    i_in_item.blue_planes[8 + 7 - p],   i_in_item.blue_planes[7 - p]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_work <= n_work;
    end

    assign o_work = r_work;
endmodule

// ===== rtl/core/prpe_queue.sv =====
// Short queue of decoded work between the input stage and the lookup stage.
module prpe_queue #(
    parameter int DEPTH = prpe_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  prpe_pkg::t_work  i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output prpe_pkg::t_work  o_data
);
    import prpe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_work           r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("queue underflow");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a push");
endmodule

// ===== rtl/core/prpe_back.sv =====
// Lookup stage: writes the palette, reads eight entries per column, expands colors.
module prpe_back #(
    parameter int PAL_DEPTH = prpe_pkg::PAL_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  prpe_pkg::t_work      i_work,
    output logic                 o_pop,
    input  logic                 i_display_enable,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output prpe_pkg::t_out_item  o_out_item
);
    import prpe_pkg::*;

    logic [PIX_NUM_W-1:0]    r_cnt;
    logic                    r_s1_valid;
    logic [PIX_NUM_W-1:0]    r_s1_num;
    logic                    r_out_valid;
    t_out_item               r_out_item;
    logic                    out_load;
    logic                    is_write;
    logic                    issue;
    logic [PAL_ENTRY_W-1:0]  rdata;
    logic [COLOR_W-1:0]      color;

    assign out_load = !r_out_valid || !i_out_stall;
    assign is_write = !i_empty && (i_work.op == OP_WRITE);
    assign issue    = !i_empty && (i_work.op == OP_COLUMN) && (!r_s1_valid || out_load);
    assign o_pop    = is_write || (issue && (r_cnt == PIX_NUM_W'(PIX_PER_COL - 1)));

    prpe_ram #(
        .WIDTH (PAL_ENTRY_W),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (is_write),
        .i_waddr (i_work.windex[$clog2(PAL_DEPTH)-1:0]),
        .i_wdata (i_work.wdata),
        .i_re    (issue),
        .i_raddr (i_work.idx[r_cnt][$clog2(PAL_DEPTH)-1:0]),
        .o_rdata (rdata)
    );

    assign color = i_display_enable
                 ? {expand_level(rdata[11:8]), expand_level(rdata[7:4]),
                    expand_level(rdata[3:0])}
                 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_s1_valid <= issue || (r_s1_valid && !out_load);
            if (out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
        if (issue) begin
            r_s1_num <= r_cnt;
        end
        if (out_load) begin
            r_out_item.pixel_color  <= color;
            r_out_item.pixel_number <= r_s1_num;
            r_out_item.last_pixel   <= (r_s1_num == PIX_NUM_W'(PIX_PER_COL - 1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_held_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_load) |=> r_s1_valid && $stable(r_s1_num) && $stable(rdata))
        else $error("pending palette read was lost");
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(is_write && issue)) else $error("palette write and read in one cycle");
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.last_pixel ==
            (o_out_item.pixel_number == PIX_NUM_W'(PIX_PER_COL - 1)))
        else $error("last pixel flag out of step");
endmodule
